### rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII emitter.
// No dependencies.
package b2da_pkg;

  localparam int unsigned DIGIT_W       = 4;  // one BCD digit
  localparam int unsigned BITS_PER_STEP = 4;  // value bits shifted per convert cycle
  localparam int unsigned CHAR_W        = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'd10;

  localparam logic [DIGIT_W-1:0] DD_THRESHOLD = 4'd5;  // add-3 trigger
  localparam logic [DIGIT_W-1:0] DD_ADJUST    = 4'd3;

endpackage

### rtl/b2da_fifo.sv
// Small flop-based queue between the converter front and the emitter back.
// No dependencies.
module b2da_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNTW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        count_q <= CNTW'(count_q + 1'b1);
      end else if (pop && !push) begin
        count_q <= CNTW'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/b2da_front.sv
// Front end: accepts a value and converts it to BCD by shift-and-add-3,
// BITS_PER_STEP bits per cycle, then hands digits and digit count onward.
// Depends on b2da_pkg.
module b2da_front
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned NUM_DIGITS  = 5,
  parameter int unsigned CNT_W       = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o,
  output logic [CNT_W-1:0]              num_sig_o
);

  localparam int unsigned STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PW     = STEPS * BITS_PER_STEP;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);
  localparam int unsigned BW     = NUM_DIGITS * DIGIT_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_DONE
  } front_state_e;

  front_state_e      state_q;
  logic [STEP_W-1:0] steps_q;
  logic [PW-1:0]     sh_q, sh_d;
  logic [BW-1:0]     bcd_q, bcd_d;
  logic              accept;

  assign in_ready_o  = (state_q == F_IDLE);
  assign out_valid_o = (state_q == F_DONE);
  assign accept      = in_valid_i && in_ready_o;
  assign bcd_o       = bcd_q;

  // Shift-and-add-3 over one group of input bits.
  always_comb begin
    logic [BW-1:0] b;
    logic [PW-1:0] s;
    b = bcd_q;
    s = sh_q;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d*DIGIT_W +: DIGIT_W] >= DD_THRESHOLD) begin
          b[d*DIGIT_W +: DIGIT_W] = DIGIT_W'(b[d*DIGIT_W +: DIGIT_W] + DD_ADJUST);
        end
      end
      b = {b[BW-2:0], s[PW-1]};
      s = {s[PW-2:0], 1'b0};
    end
    bcd_d = b;
    sh_d  = s;
  end

  // Count of significant digits; zero still prints one digit.
  always_comb begin
    num_sig_o = CNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
        num_sig_o = CNT_W'(d + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      steps_q <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            state_q <= F_CONV;
            steps_q <= STEP_W'(STEPS);
          end
        end
        F_CONV: begin
          steps_q <= STEP_W'(steps_q - 1'b1);
          if (steps_q == STEP_W'(1)) begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          if (out_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sh_q  <= PW'(value_i);
      bcd_q <= '0;
    end else if (state_q == F_CONV) begin
      sh_q  <= sh_d;
      bcd_q <= bcd_d;
    end
  end

endmodule

### rtl/b2da_back.sv
// Back end: takes a converted value from the queue and emits its digits,
// most significant first, then a newline flagged as last.
// Depends on b2da_pkg.
module b2da_back
  import b2da_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 5,
  parameter int unsigned CNT_W      = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  input  logic [CNT_W-1:0]              num_sig_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CHAR_W-1:0]             char_o,
  output logic                          last_o
);

  localparam int unsigned IW = $clog2(NUM_DIGITS);
  localparam int unsigned BW = NUM_DIGITS * DIGIT_W;

  logic              busy_q;     // holding a value to emit
  logic              newline_q;  // next char is the newline
  logic [IW-1:0]     idx_q;
  logic [BW-1:0]     bcd_q;
  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              out_free, pop;
  logic [DIGIT_W-1:0] cur_digit;

  assign out_free    = !valid_q || out_ready_i;
  assign in_ready_o  = !busy_q || (out_free && newline_q);
  assign pop         = in_valid_i && in_ready_o;
  assign cur_digit   = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
  assign out_valid_o = valid_q;
  assign char_o      = char_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      newline_q <= 1'b0;
      idx_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (out_free) begin
        valid_q <= busy_q;
      end
      // A pop while busy only happens as the newline leaves, so the next
      // value simply takes over.
      if (pop) begin
        busy_q    <= 1'b1;
        newline_q <= 1'b0;
        idx_q     <= IW'(num_sig_i - 1'b1);
      end else if (out_free && busy_q) begin
        if (newline_q) begin
          busy_q <= 1'b0;
        end else if (idx_q == '0) begin
          newline_q <= 1'b1;
        end else begin
          idx_q <= IW'(idx_q - 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      bcd_q <= bcd_i;
    end
    if (out_free && busy_q) begin
      char_q <= newline_q ? ASCII_NEWLINE : (ASCII_ZERO | CHAR_W'(cur_digit));
      last_q <= newline_q;
    end
  end

endmodule

### rtl/binary_to_decimal_ascii_emitter.sv
// Top level of the binary to decimal ASCII emitter.
// Depends on b2da_pkg, b2da_front, b2da_fifo and b2da_back.
//
// Usage:
//   Input stream (s_axis_*): one unsigned value per item in tdata; bits of
//   tdata above VALUE_WIDTH are ignored.
//   Output stream (m_axis_*): one ASCII character per item, digits most
//   significant first with leading zeros dropped (zero prints '0'), then a
//   newline (10) with tlast high that closes the run.
//   Flow: the front converts by shift-and-add-3, four value bits per
//   step, then hands digits and digit count to the queue; the back pops
//   the queue and emits each character from an output register.
//   Throughput: the character port sends one item per cycle while
//   m_axis_tready is high, so a value occupies digits + 1 items, at most 6
//   for 16 bits; the front takes one value at a time and accepts the next
//   only once the result is in the queue. A two-entry queue lets the front
//   convert the next value while the back still emits the current one.
//   Reset clears all control state; the block is then empty and ready.
//   A stall on m_axis_tready holds the current character; the queue then
//   fills and s_axis_tready drops until room frees up.
module binary_to_decimal_ascii_emitter
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: [VALUE_WIDTH-1:0] value, zero padded to whole bytes
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: [7:0] character
  output logic [CHAR_W-1:0]                     m_axis_tdata,
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready
);

  // Decimal digits needed for 2^VALUE_WIDTH-1 (1233/4096 ~ log10(2)).
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned BW         = NUM_DIGITS * DIGIT_W;
  localparam int unsigned QW         = BW + CNT_W;
  localparam int unsigned Q_DEPTH    = 2;

  logic             f_valid, f_ready;
  logic [BW-1:0]    f_bcd;
  logic [CNT_W-1:0] f_num;
  logic             q_valid, q_ready;
  logic [QW-1:0]    q_data;

  b2da_front #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NUM_DIGITS),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .value_i    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .bcd_o      (f_bcd),
    .num_sig_o  (f_num)
  );

  b2da_fifo #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i ({f_num, f_bcd}),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_data)
  );

  b2da_back #(
    .NUM_DIGITS(NUM_DIGITS),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .bcd_i      (q_data[BW-1:0]),
    .num_sig_i  (q_data[QW-1:BW]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .char_o     (m_axis_tdata),
    .last_o     (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  // The run terminator is always the newline.
  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == ASCII_NEWLINE))
    else $error("last item is not a newline");

  // Every other character is a decimal digit.
  a_body_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      (m_axis_tdata >= ASCII_ZERO && m_axis_tdata <= ASCII_ZERO + 8'd9))
    else $error("non-digit character in run body");

  // A converted value held by the front never gets dropped while it waits.
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !f_ready) |=> (f_valid && $stable(f_bcd)))
    else $error("front result lost while queue full");
`endif

endmodule
